// ----- hw/rtl/mie_pkg.sv -----
// Package for the modular inverse block: widths, reset modulus and status codes.
// No dependencies.
`default_nettype none
package mie_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned CntW = $clog2(Width + 1);
  localparam logic [Width-1:0] ModulusReset = Width'(2);
  localparam logic StatusOk = 1'b0;
  localparam logic StatusNone = 1'b1;
endpackage
`default_nettype wire

// ----- hw/rtl/mie_divmod.sv -----
// Bit-serial divider and modular multiply-subtract unit for one Euclid step.
// Depends on mie_pkg.
`default_nettype none
module mie_divmod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [mie_pkg::Width-1:0] m_i,
  input  logic [mie_pkg::Width-1:0] num_i,
  input  logic [mie_pkg::Width-1:0] den_i,
  input  logic [mie_pkg::Width-1:0] t0_i,
  input  logic [mie_pkg::Width-1:0] t1_i,
  output logic                    done_o,
  output logic [mie_pkg::Width-1:0] rem_o,
  output logic [mie_pkg::Width-1:0] t_o
);
  localparam int unsigned W = mie_pkg::Width;
  typedef enum logic [3:0] {
    SIdle = 4'b0001, SDiv = 4'b0010, SMul = 4'b0100, SFin = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [mie_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0] q_q, q_d, rem_q, rem_d, acc_q, acc_d;
  logic [W:0] trial;
  logic [W-1:0] dbl, room_a, add_b, room_b, mt;

  always_comb begin
    trial = {rem_q, q_q[W-1]} - {1'b0, den_i};
    room_a = m_i - acc_q;
    dbl = (acc_q >= room_a) ? acc_q - room_a : acc_q + acc_q;
    room_b = m_i - t1_i;
    add_b = (dbl >= room_b) ? dbl - room_b : dbl + t1_i;
    mt = (acc_q == '0) ? '0 : m_i - acc_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    q_d = q_q;
    rem_d = rem_q;
    acc_d = acc_q;
    done_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          q_d = num_i;
          rem_d = '0;
          cnt_d = mie_pkg::CntW'(W);
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          q_d = {q_q[W-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[W-2:0], q_q[W-1]};
          q_d = {q_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == mie_pkg::CntW'(1)) begin
          cnt_d = mie_pkg::CntW'(W);
          acc_d = '0;
          state_d = SMul;
        end
      end
      SMul: begin
        acc_d = q_q[W-1] ? add_b : dbl;
        q_d = {q_q[W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == mie_pkg::CntW'(1)) state_d = SFin;
      end
      SFin: begin
        acc_d = (t0_i >= m_i - mt) ? t0_i - (m_i - mt) : t0_i + mt;
        done_o = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign rem_o = rem_q;
  assign t_o = acc_d;
endmodule
`default_nettype wire

// ----- hw/rtl/modular_inverse_euclid.sv -----
// Top level of the modular inverse block: Euclid loop control and result strobe.
// Depends on mie_pkg and mie_divmod.
`default_nettype none
// Computes value^-1 mod modulus by the extended Euclidean algorithm. The first
// reduction of value modulo modulus and each Euclid step run the shared bit-serial
// unit: a load, restoring division, shift-and-add modular multiply and a fold of
// the old coefficient, in that order. The time from the accepting edge to the
// result strobe is set by the number of Euclid steps; for 32 bits that is at most
// 45 steps. A modulus below 2 answers in the cycle after start is accepted. busy
// stays high until the result strobe; the result is shown for one cycle on
// valid_o and cannot be stalled.
module modular_inverse_euclid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [31:0] inverse_o,
  output logic        status_o
);
  localparam int unsigned W = mie_pkg::Width;
  typedef enum logic [3:0] {
    SIdle = 4'b0001, SRed = 4'b0010, SStep = 4'b0100, SWait = 4'b1000
  } state_e;

  state_e state_q;
  logic [W-1:0] mod_q, r0_q, r1_q, t0_q, t1_q;
  logic valid_q, status_q;
  logic [W-1:0] inv_q;
  logic [W-1:0] val_q;
  logic du_start, du_done;
  logic [W-1:0] du_num, du_den, du_t0, du_rem, du_t;
  logic red_q;

  assign busy = (state_q != SIdle);
  assign du_num = red_q ? val_q : r0_q;
  assign du_den = red_q ? mod_q : r1_q;
  assign du_t0 = red_q ? '0 : t0_q;
  assign du_start = (state_q == SRed) || (state_q == SStep);

  mie_divmod u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(du_start), .m_i(mod_q),
    .num_i(du_num), .den_i(du_den), .t0_i(du_t0), .t1_i(t1_q),
    .done_o(du_done), .rem_o(du_rem), .t_o(du_t)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mod_q <= mie_pkg::ModulusReset;
      valid_q <= 1'b0;
      red_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      unique case (state_q)
        SIdle: begin
          if (start) begin
            if (mod_q < W'(2)) begin
              valid_q <= 1'b1;
            end else begin
              red_q <= 1'b1;
              state_q <= SRed;
            end
          end
        end
        SRed, SStep: state_q <= SWait;
        SWait: begin
          if (du_done) begin
            red_q <= 1'b0;
            if (red_q) begin
              if (du_rem == '0) begin
                valid_q <= 1'b1;
                state_q <= SIdle;
              end else state_q <= SStep;
            end else if (du_rem == '0) begin
              valid_q <= 1'b1;
              state_q <= SIdle;
            end else state_q <= SStep;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start) begin
      inv_q <= '0;
      status_q <= mie_pkg::StatusNone;
      t0_q <= '0;
      t1_q <= W'(1);
      val_q <= value_i;
    end
    if (state_q == SWait && du_done) begin
      if (red_q) begin
        r0_q <= mod_q;
        r1_q <= du_rem;
        if (du_rem == '0) begin
          inv_q <= '0;
          status_q <= mie_pkg::StatusNone;
        end
      end else begin
        r0_q <= r1_q;
        r1_q <= du_rem;
        t0_q <= t1_q;
        t1_q <= du_t;
        if (du_rem == '0) begin
          if (r1_q == W'(1)) begin
            inv_q <= t1_q;
            status_q <= mie_pkg::StatusOk;
          end else begin
            inv_q <= '0;
            status_q <= mie_pkg::StatusNone;
          end
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign inverse_o = inv_q;
  assign status_o = status_q;
endmodule
`default_nettype wire
